/* rtl/rgbe_rle_pkg.sv */
`default_nettype none

package rgbe_rle_pkg;

    // line geometry
    localparam int MAX_LINE_WIDTH = 32767;
    localparam int PIX_W          = 15;
    localparam int BYTE_W         = 8;
    localparam int MASK_W         = 4;

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = PIX_W;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEW_MIN_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEW_MAX_WIDTH = 2'd2;

    localparam logic [PIX_W-1:0] RST_LINE_WIDTH    = 15'd1;
    localparam logic [PIX_W-1:0] RST_NEW_MIN_WIDTH = 15'd8;
    localparam logic [PIX_W-1:0] RST_NEW_MAX_WIDTH = 15'd32767;

    // stream codes
    localparam logic [BYTE_W-1:0] HDR_MARK    = 8'd2;
    localparam logic [BYTE_W-1:0] RUN_FLAG    = 8'd128;
    localparam logic [BYTE_W-1:0] REPEAT_MARK = 8'd1;

    // result queue between decoder and output side
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [PIX_W-1:0] line_width;
        logic [PIX_W-1:0] new_min_width;
        logic [PIX_W-1:0] new_max_width;
    } t_cfg;

    typedef struct packed {
        logic [MASK_W-1:0] channel_mask;
        logic [PIX_W-1:0]  first_pixel;
        logic [PIX_W-1:0]  pixel_count;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] exponent;
        logic              line_end;
        logic              overrun;
    } t_result;

endpackage

`default_nettype wire

/* rtl/rgbe_rle_queue.sv */
`default_nettype none

module rgbe_rle_queue (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_wr,
    input  rgbe_rle_pkg::t_result  i_wr_data,
    input  wire                    i_rd,
    output rgbe_rle_pkg::t_result  o_rd_data,
    output logic                   o_full,
    output logic                   o_empty
);
    import rgbe_rle_pkg::*;

    t_result               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0]   r_count, n_count;

    localparam logic [QUEUE_AW-1:0] LAST_SLOT = QUEUE_AW'(QUEUE_DEPTH - 1);
    localparam logic [QUEUE_CW-1:0] FULL_CNT  = QUEUE_CW'(QUEUE_DEPTH);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_rd) begin
            n_rd_ptr = (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + 1'b1;
        end else if (i_rd && !i_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_mem[r_rd_ptr];
    assign o_full    = (r_count == FULL_CNT);
    assign o_empty   = (r_count == '0);

endmodule

`default_nettype wire

/* rtl/rgbe_rle_front.sv */
`default_nettype none

module rgbe_rle_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  rgbe_rle_pkg::t_cfg           i_cfg,
    input  wire                          i_valid,
    input  wire [rgbe_rle_pkg::BYTE_W-1:0] i_data_byte,
    output logic                         o_res_valid,
    output rgbe_rle_pkg::t_result        o_res
);
    import rgbe_rle_pkg::*;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_HDR_G  = 3'd1,
        PH_HDR_B  = 3'd2,
        PH_HDR_E  = 3'd3,
        PH_OLD    = 3'd4,
        PH_CODE   = 3'd5,
        PH_RUNVAL = 3'd6,
        PH_LIT    = 3'd7
    } t_phase;

    localparam logic [PIX_W-1:0] MAX_W = PIX_W'(MAX_LINE_WIDTH);

    t_phase             r_phase, n_phase;
    logic [1:0]         r_bip, n_bip;
    logic [PIX_W-1:0]   r_pos, n_pos;
    logic [1:0]         r_plane, n_plane;
    logic [6:0]         r_rem, n_rem;
    logic [1:0]         r_rshift, n_rshift;
    logic [23:0]        r_partial, n_partial;
    logic [31:0]        r_prev, n_prev;

    logic [PIX_W-1:0]   w_eff;
    logic [PIX_W-1:0]   avail;
    logic [BYTE_W-1:0]  b;

    // old-style write request
    logic               do_old;
    logic [31:0]        old_pix;
    logic [16:0]        old_cnt;
    logic               old_end;
    // planar write request
    logic               do_plane;
    logic               plane_lit;
    logic               plane_more;
    logic [PIX_W-1:0]   plane_cnt;
    logic               plane_end;
    logic               plane_le;

    always_comb begin
        b = i_data_byte;
        if (i_cfg.line_width == '0) begin
            w_eff = PIX_W'(1);
        end else if (i_cfg.line_width > MAX_W) begin
            w_eff = MAX_W;
        end else begin
            w_eff = i_cfg.line_width;
        end
        avail = (r_pos < w_eff) ? (w_eff - r_pos) : PIX_W'(1);
    end

    always_comb begin
        n_phase   = r_phase;
        n_bip     = r_bip;
        n_pos     = r_pos;
        n_plane   = r_plane;
        n_rem     = r_rem;
        n_rshift  = r_rshift;
        n_partial = r_partial;
        n_prev    = r_prev;

        do_old     = 1'b0;
        old_pix    = r_prev;
        old_cnt    = 17'd1;
        old_end    = 1'b0;
        do_plane   = 1'b0;
        plane_lit  = 1'b0;
        plane_more = 1'b0;
        plane_cnt  = PIX_W'(1);
        plane_end  = 1'b0;
        plane_le   = 1'b0;

        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_valid) begin
            unique case (r_phase)
                PH_START: begin
                    n_pos   = '0;
                    n_plane = '0;
                    if (w_eff < i_cfg.new_min_width || w_eff > i_cfg.new_max_width ||
                        b != HDR_MARK) begin
                        n_rshift  = '0;
                        n_partial = {16'd0, b};
                        n_bip     = 2'd1;
                        n_phase   = PH_OLD;
                    end else begin
                        n_phase = PH_HDR_G;
                    end
                end
                PH_HDR_G: begin
                    n_partial = {8'd0, b, 8'd0};
                    n_phase   = PH_HDR_B;
                end
                PH_HDR_B: begin
                    n_partial = {b, r_partial[15:8], 8'd0};
                    n_phase   = PH_HDR_E;
                end
                PH_HDR_E: begin
                    if (r_partial[15:8] != HDR_MARK || r_partial[23]) begin
                        // not a planar header: first four bytes are pixel 0
                        old_pix  = {b, r_partial[23:8], HDR_MARK};
                        n_prev   = old_pix;
                        n_rshift = '0;
                        n_bip    = '0;
                        n_pos    = '0;
                        do_old   = 1'b1;
                    end else begin
                        n_plane = '0;
                        n_pos   = '0;
                        n_phase = PH_CODE;
                    end
                end
                PH_OLD: begin
                    unique case (r_bip)
                        2'd0: begin
                            n_partial = {16'd0, b};
                            n_bip     = 2'd1;
                        end
                        2'd1: begin
                            n_partial = {r_partial[23:16], b, r_partial[7:0]};
                            n_bip     = 2'd2;
                        end
                        2'd2: begin
                            n_partial = {b, r_partial[15:0]};
                            n_bip     = 2'd3;
                        end
                        default: begin
                            n_bip = '0;
                            if (r_partial[7:0] == REPEAT_MARK &&
                                r_partial[15:8] == REPEAT_MARK &&
                                r_partial[23:16] == REPEAT_MARK) begin
                                // repeat count shifted by 8 bits per prior repeat;
                                // shifts of 16 or more always pass the line end
                                unique case (r_rshift)
                                    2'd0:    old_cnt = {9'd0, b};
                                    2'd1:    old_cnt = {1'b0, b, 8'd0};
                                    default: old_cnt = (b != '0) ? 17'h10000 : 17'd0;
                                endcase
                                if (r_rshift != 2'd3) begin
                                    n_rshift = r_rshift + 1'b1;
                                end
                                old_pix = r_prev;
                                do_old  = (b != '0);
                            end else begin
                                old_pix  = {b, r_partial};
                                n_prev   = old_pix;
                                n_rshift = '0;
                                do_old   = 1'b1;
                            end
                        end
                    endcase
                end
                PH_CODE: begin
                    if (b > RUN_FLAG) begin
                        n_rem   = b[6:0];
                        n_phase = PH_RUNVAL;
                    end else if (b != '0) begin
                        n_rem   = 7'(b - 1'b1);
                        n_phase = PH_LIT;
                    end
                end
                PH_RUNVAL: begin
                    do_plane  = 1'b1;
                    plane_cnt = {8'd0, r_rem};
                end
                PH_LIT: begin
                    do_plane   = 1'b1;
                    plane_lit  = 1'b1;
                    plane_more = (r_rem != '0);
                end
            endcase
        end

        if (do_old) begin
            old_end     = (old_cnt >= {2'b00, avail});
            o_res_valid = 1'b1;
            o_res.channel_mask = '1;
            o_res.first_pixel  = n_pos;
            o_res.pixel_count  = old_end ? avail : old_cnt[PIX_W-1:0];
            o_res.red          = old_pix[7:0];
            o_res.green        = old_pix[15:8];
            o_res.blue         = old_pix[23:16];
            o_res.exponent     = old_pix[31:24];
            o_res.line_end     = old_end;
            o_res.overrun      = (old_cnt > {2'b00, avail});
            if (old_end) begin
                n_pos    = '0;
                n_bip    = '0;
                n_rshift = '0;
                n_phase  = PH_START;
            end else begin
                n_pos   = n_pos + old_cnt[PIX_W-1:0];
                n_phase = PH_OLD;
            end
        end

        if (do_plane) begin
            plane_end   = (plane_cnt >= avail);
            plane_le    = plane_end && (r_plane == 2'd3);
            o_res_valid = 1'b1;
            o_res.channel_mask = MASK_W'(1) << r_plane;
            o_res.first_pixel  = r_pos;
            o_res.pixel_count  = plane_end ? avail : plane_cnt;
            o_res.red          = (r_plane == 2'd0) ? b : '0;
            o_res.green        = (r_plane == 2'd1) ? b : '0;
            o_res.blue         = (r_plane == 2'd2) ? b : '0;
            o_res.exponent     = (r_plane == 2'd3) ? b : '0;
            o_res.line_end     = plane_le;
            o_res.overrun      = plane_end && ((plane_cnt > avail) || plane_more);
            if (plane_end) begin
                // leftover literal bytes are dropped at the plane end
                n_pos = '0;
                n_rem = '0;
                if (plane_le) begin
                    n_plane = '0;
                    n_phase = PH_START;
                end else begin
                    n_plane = r_plane + 1'b1;
                    n_phase = PH_CODE;
                end
            end else begin
                n_pos   = r_pos + plane_cnt;
                n_phase = PH_CODE;
                if (plane_lit && plane_more) begin
                    n_rem   = r_rem - 1'b1;
                    n_phase = PH_LIT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_START;
            r_bip     <= '0;
            r_pos     <= '0;
            r_plane   <= '0;
            r_rem     <= '0;
            r_rshift  <= '0;
            r_partial <= '0;
            r_prev    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_bip     <= n_bip;
            r_pos     <= n_pos;
            r_plane   <= n_plane;
            r_rem     <= n_rem;
            r_rshift  <= n_rshift;
            r_partial <= n_partial;
            r_prev    <= n_prev;
        end
    end

endmodule

`default_nettype wire

/* rtl/rgbe_scanline_rle_decoder.sv */
`default_nettype none

// rgbe scanline run-length decoder
//
// input channel: one byte of compressed picture data per transaction,
//   taken when push is high and full is low
// result channel: fill commands for a line memory (channel mask, first
//   pixel, pixel count, channel values, line end, overrun); the oldest
//   command sits on the o_ ports while empty is low and leaves when pop is high
// configuration: i_cfg_wr_en writes i_cfg_data into register i_cfg_idx
//   (0 line width, 1 smallest planar width, 2 largest planar width),
//   index 3 is ignored; write only while the block is idle
// throughput: one byte per cycle while full is low; a byte yields zero or one
//   command, and the decode state is updated in the cycle the byte is taken
// result path: commands are registered in the queue and leave in order
// stalls: commands collect in a four-entry queue; full rises only when
//   that queue is full, so the input keeps flowing while the receiver waits
// reset: synchronous, active low; queue empties, registers go back to
//   width 1 and planar window 8 to 32767, decoder waits for a line start
module rgbe_scanline_rle_decoder (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // configuration
    input  wire                                  i_cfg_wr_en,
    input  wire [rgbe_rle_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [rgbe_rle_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    // byte stream in
    input  wire                                  push,
    output logic                                 full,
    input  wire [rgbe_rle_pkg::BYTE_W-1:0]       i_data_byte,
    // fill commands out
    output logic                                 empty,
    input  wire                                  pop,
    output logic [rgbe_rle_pkg::MASK_W-1:0]      o_channel_mask,
    output logic [rgbe_rle_pkg::PIX_W-1:0]       o_first_pixel,
    output logic [rgbe_rle_pkg::PIX_W-1:0]       o_pixel_count,
    output logic [rgbe_rle_pkg::BYTE_W-1:0]      o_red,
    output logic [rgbe_rle_pkg::BYTE_W-1:0]      o_green,
    output logic [rgbe_rle_pkg::BYTE_W-1:0]      o_blue,
    output logic [rgbe_rle_pkg::BYTE_W-1:0]      o_exponent,
    output logic                                 o_line_end,
    output logic                                 o_overrun
);
    import rgbe_rle_pkg::*;

    t_cfg     r_cfg;
    logic     byte_take;     // input transaction this cycle
    logic     res_valid;     // decoder produced a command
    t_result  res;
    t_result  head;          // oldest queued command
    logic     q_full;
    logic     q_empty;
    logic     res_take;      // output transaction this cycle

    // configuration registers, written straight from the port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_width    <= RST_LINE_WIDTH;
            r_cfg.new_min_width <= RST_NEW_MIN_WIDTH;
            r_cfg.new_max_width <= RST_NEW_MAX_WIDTH;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                REG_LINE_WIDTH:    r_cfg.line_width    <= i_cfg_data;
                REG_NEW_MIN_WIDTH: r_cfg.new_min_width <= i_cfg_data;
                REG_NEW_MAX_WIDTH: r_cfg.new_max_width <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a byte is only taken when the queue can hold whatever it produces
    assign byte_take = push && !q_full;
    assign res_take  = pop && !q_empty;

    // front: parse bytes, track line position, build commands
    rgbe_rle_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (byte_take),
        .i_data_byte (i_data_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // back: command queue feeding the result ports
    rgbe_rle_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (res_valid),
        .i_wr_data (res),
        .i_rd      (res_take),
        .o_rd_data (head),
        .o_full    (q_full),
        .o_empty   (q_empty)
    );

    assign full           = q_full;
    assign empty          = q_empty;
    assign o_channel_mask = head.channel_mask;
    assign o_first_pixel  = head.first_pixel;
    assign o_pixel_count  = head.pixel_count;
    assign o_red          = head.red;
    assign o_green        = head.green;
    assign o_blue         = head.blue;
    assign o_exponent     = head.exponent;
    assign o_line_end     = head.line_end;
    assign o_overrun      = head.overrun;

endmodule

`default_nettype wire

/* dv/tb_rgbe_scanline_rle_decoder.sv */
`default_nettype none

module tb_rgbe_scanline_rle_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import rgbe_rle_pkg::*;

    // clocking and run length
    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 400;
    // quiet cycles after the last fill command before touching registers
    localparam int IDLE_SETTLE  = 4;
    // planar lines wider than this cost too many bytes to generate
    localparam int PLANAR_GEN_MAX = 300;
    localparam logic [BYTE_W-1:0] RUN_LEN_MASK = 8'h7F;

    // decoder phases of the local line predictor
    typedef enum logic [2:0] {
        DEC_LINE_START,
        DEC_HDR_G,
        DEC_HDR_B,
        DEC_HDR_E,
        DEC_OLD_PIXEL,
        DEC_CODE,
        DEC_RUN_VALUE,
        DEC_LITERAL
    } t_dec_phase;

    // dut connections, all inputs known from time zero
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data  = '0;
    logic                 push        = 1'b0;
    logic                 full;
    logic [BYTE_W-1:0]    i_data_byte = '0;
    logic                 empty;
    logic                 pop         = 1'b0;
    logic [MASK_W-1:0]    o_channel_mask;
    logic [PIX_W-1:0]     o_first_pixel;
    logic [PIX_W-1:0]     o_pixel_count;
    logic [BYTE_W-1:0]    o_red;
    logic [BYTE_W-1:0]    o_green;
    logic [BYTE_W-1:0]    o_blue;
    logic [BYTE_W-1:0]    o_exponent;
    logic                 o_line_end;
    logic                 o_overrun;

    rgbe_scanline_rle_decoder DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_data_byte    (i_data_byte),
        .empty          (empty),
        .pop            (pop),
        .o_channel_mask (o_channel_mask),
        .o_first_pixel  (o_first_pixel),
        .o_pixel_count  (o_pixel_count),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_exponent     (o_exponent),
        .o_line_end     (o_line_end),
        .o_overrun      (o_overrun)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // fill commands predicted but not yet seen on the output side
    t_result fill_cmd_q[$];

    // local copy of the registers and the line decode state
    t_cfg        dec_cfg;
    t_dec_phase  st_phase;
    int unsigned st_byte_idx;
    int unsigned st_pos;
    int unsigned st_plane;
    int unsigned st_remain;
    bit          st_is_run;
    int unsigned st_rep_shift;
    logic [31:0] st_partial;
    logic [31:0] st_prev;

    // bookkeeping
    int          fail_cnt     = 0;
    int unsigned bytes_sent   = 0;
    int unsigned cmds_checked = 0;
    int unsigned lines_ended  = 0;
    int unsigned overruns     = 0;
    int unsigned cfg_settings = 0;
    int unsigned cycle_cnt    = 0;

    // sender burst state
    int unsigned burst_left = 0;

    // receiver stall pattern
    int unsigned rx_mode  = 0;
    int unsigned rx_tick  = 0;
    int unsigned rx_next  = 64;
    logic        rx_flush = 1'b0;

    // ------------------------------------------------------------------
    // line predictor
    // ------------------------------------------------------------------

    task automatic reset_predictor();
        dec_cfg.line_width    = RST_LINE_WIDTH;
        dec_cfg.new_min_width = RST_NEW_MIN_WIDTH;
        dec_cfg.new_max_width = RST_NEW_MAX_WIDTH;
        st_phase     = DEC_LINE_START;
        st_byte_idx  = 0;
        st_pos       = 0;
        st_plane     = 0;
        st_remain    = 0;
        st_is_run    = 1'b0;
        st_rep_shift = 0;
        st_partial   = '0;
        st_prev      = '0;
    endtask

    // width zero acts as one, anything above the maximum is clamped
    function automatic int unsigned eff_width();
        int unsigned w;
        w = dec_cfg.line_width;
        if (w == 0) w = 1;
        if (w > MAX_LINE_WIDTH) w = MAX_LINE_WIDTH;
        return w;
    endfunction

    // a position already past a shrunk width still gets one pixel
    function automatic int unsigned px_left(input int unsigned w);
        return (st_pos < w) ? (w - st_pos) : 1;
    endfunction

    function automatic bit planar_allowed();
        int unsigned w;
        w = eff_width();
        return (w >= dec_cfg.new_min_width) && (w <= dec_cfg.new_max_width);
    endfunction

    // whole old-style pixel written count times, clamped at line end
    task automatic old_fill(input logic [31:0] pix, input longint unsigned count,
                            input int unsigned w, output t_result cmd);
        int unsigned avail;
        int unsigned cnt;
        bit          last;
        bit          ov;
        avail = px_left(w);
        last  = 1'b0;
        ov    = 1'b0;
        if (count >= avail) begin
            ov   = (count > avail);
            cnt  = avail;
            last = 1'b1;
        end else begin
            cnt = int'(count);
        end
        cmd.channel_mask = 4'hF;
        cmd.first_pixel  = PIX_W'(st_pos);
        cmd.pixel_count  = PIX_W'(cnt);
        cmd.red          = pix[7:0];
        cmd.green        = pix[15:8];
        cmd.blue         = pix[23:16];
        cmd.exponent     = pix[31:24];
        cmd.line_end     = last;
        cmd.overrun      = ov;
        if (last) begin
            st_pos       = 0;
            st_byte_idx  = 0;
            st_rep_shift = 0;
            st_phase     = DEC_LINE_START;
        end else begin
            st_pos   = st_pos + cnt;
            st_phase = DEC_OLD_PIXEL;
        end
    endtask

    // one channel value over count pixels of the current plane
    task automatic plane_fill(input logic [7:0] val, input int unsigned count,
                              input bit more, input int unsigned w,
                              output t_result cmd, output bit plane_done);
        int unsigned avail;
        int unsigned cnt;
        bit          ov;
        bit          le;
        avail      = px_left(w);
        cnt        = count;
        ov         = 1'b0;
        le         = 1'b0;
        plane_done = 1'b0;
        if (count >= avail) begin
            ov         = (count > avail) || more;
            cnt        = avail;
            plane_done = 1'b1;
            le         = (st_plane == 3);
        end
        cmd              = '0;
        cmd.channel_mask = MASK_W'(1 << st_plane);
        cmd.first_pixel  = PIX_W'(st_pos);
        cmd.pixel_count  = PIX_W'(cnt);
        case (st_plane)
            0: cmd.red = val;
            1: cmd.green = val;
            2: cmd.blue = val;
            default: cmd.exponent = val;
        endcase
        cmd.line_end = le;
        cmd.overrun  = ov;
        if (plane_done) begin
            st_pos    = 0;
            st_remain = 0;
            st_is_run = 1'b0;
            if (le) begin
                st_plane = 0;
                st_phase = DEC_LINE_START;
            end else begin
                st_plane = (st_plane + 1) & 3;
                st_phase = DEC_CODE;
            end
        end else begin
            st_pos   = st_pos + cnt;
            st_phase = DEC_CODE;
        end
    endtask

    // advance the predictor by one stream byte
    task automatic decode_byte(input logic [7:0] b, output bit produced,
                               output t_result cmd);
        int unsigned     w;
        int unsigned     k;
        int unsigned     keep;
        logic [7:0]      g;
        logic [7:0]      bl;
        logic [31:0]     pix;
        longint unsigned rep_cnt;
        bit              done;
        bit              more;
        w        = eff_width();
        produced = 1'b0;
        cmd      = '0;
        case (st_phase)
            DEC_LINE_START: begin
                st_pos   = 0;
                st_plane = 0;
                if (!planar_allowed() || b != HDR_MARK) begin
                    st_rep_shift = 0;
                    st_partial   = {24'h0, b};
                    st_byte_idx  = 1;
                    st_phase     = DEC_OLD_PIXEL;
                end else begin
                    st_phase = DEC_HDR_G;
                end
            end
            DEC_HDR_G: begin
                st_partial = {16'h0, b, 8'h00};
                st_phase   = DEC_HDR_B;
            end
            DEC_HDR_B: begin
                st_partial = {8'h00, b, st_partial[15:8], 8'h00};
                st_phase   = DEC_HDR_E;
            end
            DEC_HDR_E: begin
                g  = st_partial[15:8];
                bl = st_partial[23:16];
                // header fallback: the four bytes are the first pixel
                if (g != HDR_MARK || bl[7]) begin
                    pix          = {b, bl, g, HDR_MARK};
                    st_prev      = pix;
                    st_rep_shift = 0;
                    st_byte_idx  = 0;
                    st_pos       = 0;
                    old_fill(pix, 1, w, cmd);
                    produced = 1'b1;
                end else begin
                    // width bytes of the header are not used
                    st_plane = 0;
                    st_pos   = 0;
                    st_phase = DEC_CODE;
                end
            end
            DEC_OLD_PIXEL: begin
                k = st_byte_idx & 3;
                if (k < 3) begin
                    if (k == 0) st_partial = {24'h0, b};
                    else st_partial = (st_partial & 32'h00FF_FFFF) | (32'(b) << (8 * k));
                    st_byte_idx = k + 1;
                end else begin
                    st_byte_idx = 0;
                    if (st_partial[7:0] == REPEAT_MARK && st_partial[15:8] == REPEAT_MARK
                            && st_partial[23:16] == REPEAT_MARK) begin
                        // repeat pixel, each consecutive one shifts 8 more bits
                        rep_cnt = longint'(b) << (8 * (st_rep_shift & 3));
                        if (st_rep_shift < 3) st_rep_shift++;
                        if (rep_cnt > 0) begin
                            keep = st_rep_shift;
                            old_fill(st_prev, rep_cnt, w, cmd);
                            produced = 1'b1;
                            if (st_phase == DEC_OLD_PIXEL) st_rep_shift = keep;
                        end
                    end else begin
                        pix          = {b, st_partial[23:0]};
                        st_prev      = pix;
                        st_rep_shift = 0;
                        old_fill(pix, 1, w, cmd);
                        produced = 1'b1;
                    end
                end
            end
            DEC_CODE: begin
                // a zero code is skipped
                if (b > RUN_FLAG) begin
                    st_is_run = 1'b1;
                    st_remain = b & RUN_LEN_MASK;
                    st_phase  = DEC_RUN_VALUE;
                end else if (b > 0) begin
                    st_is_run = 1'b0;
                    st_remain = b - 1;
                    st_phase  = DEC_LITERAL;
                end
            end
            DEC_RUN_VALUE: begin
                plane_fill(b, st_remain & RUN_LEN_MASK, 1'b0, w, cmd, done);
                produced = 1'b1;
            end
            default: begin
                // literal bytes left over at the plane end are dropped
                more = (st_remain & RUN_LEN_MASK) != 0;
                plane_fill(b, 1, more, w, cmd, done);
                produced = 1'b1;
                if (!done && more) begin
                    st_remain = (st_remain - 1) & RUN_LEN_MASK;
                    st_phase  = DEC_LITERAL;
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // one byte transaction; returns at the edge that takes it, push left high
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        bit          produced;
        t_result     cmd;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            // now and then a long stretch with no gaps
            burst_left = ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(1, 30);
        end
        burst_left--;
        push        <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (full);
        decode_byte(b, produced, cmd);
        if (produced) fill_cmd_q.push_back(cmd);
        bytes_sent++;
    endtask

    // sender holds off until every predicted command has come out
    task automatic drain_results();
        push      <= 1'b0;
        burst_left = 0;
        while (fill_cmd_q.size() != 0) @(posedge i_clk);
        // a byte with no command may still be in flight
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            REG_LINE_WIDTH:    dec_cfg.line_width = val;
            REG_NEW_MIN_WIDTH: dec_cfg.new_min_width = val;
            REG_NEW_MAX_WIDTH: dec_cfg.new_max_width = val;
            default: ;
        endcase
    endtask

    // all three registers, only with the block idle
    task automatic apply_config(input logic [PIX_W-1:0] w, input logic [PIX_W-1:0] mn,
                                input logic [PIX_W-1:0] mx);
        drain_results();
        write_reg(REG_LINE_WIDTH, w);
        write_reg(REG_NEW_MIN_WIDTH, mn);
        write_reg(REG_NEW_MAX_WIDTH, mx);
        i_cfg_wr_en <= 1'b0;
        cfg_settings++;
    endtask

    task automatic send_repeat(input logic [7:0] cnt);
        repeat (3) send_byte(REPEAT_MARK);
        send_byte(cnt);
    endtask

    // ------------------------------------------------------------------
    // stream generators
    // ------------------------------------------------------------------

    // well formed planar line: header then four planes of codes
    task automatic gen_planar_line(input int unsigned w);
        int unsigned left;
        int unsigned n;
        int unsigned pick;
        send_byte(HDR_MARK);
        send_byte(HDR_MARK);
        send_byte(8'($urandom_range(0, 127)));
        send_byte(8'($urandom));
        for (int p = 0; p < 4; p++) begin
            left = w;
            while (left > 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    send_byte(8'h00);
                end else if (pick < 13 && left < 127) begin
                    // run that runs past the plane end
                    n = $urandom_range(left + 1, 127);
                    send_byte(RUN_FLAG | 8'(n));
                    send_byte(8'($urandom));
                    left = 0;
                end else if (pick < 18 && left < 128) begin
                    // literal that runs past the plane end
                    n = $urandom_range(left + 1, 128);
                    send_byte(8'(n));
                    repeat (left) send_byte(8'($urandom));
                    left = 0;
                end else if (pick < 60) begin
                    n = $urandom_range(1, (left < 127) ? left : 127);
                    send_byte(RUN_FLAG | 8'(n));
                    send_byte(8'($urandom));
                    left = left - n;
                end else begin
                    n = $urandom_range(1, (left < 8) ? left : 8);
                    send_byte(8'(n));
                    repeat (n) send_byte(8'($urandom));
                    left = left - n;
                end
            end
        end
    endtask

    // old-style pixels with runs of consecutive repeat pixels
    task automatic gen_old_line();
        int unsigned npix;
        npix = $urandom_range(1, 8);
        repeat (npix) begin
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 5))
                    send_repeat(($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom));
            end else begin
                repeat (4) send_byte(8'($urandom));
            end
        end
    endtask

    // planar marker followed by a header that is not planar
    task automatic gen_fallback_line();
        logic [7:0] g;
        logic [7:0] bl;
        if ($urandom_range(0, 1) == 0) begin
            g  = 8'($urandom);
            if (g == HDR_MARK) g = g + 1;
            bl = 8'($urandom);
        end else begin
            g  = HDR_MARK;
            bl = 8'h80 | 8'($urandom);
        end
        send_byte(HDR_MARK);
        send_byte(g);
        send_byte(bl);
        send_byte(8'($urandom));
        gen_old_line();
    endtask

    // push the decoder toward a line start so the next line is well formed
    task automatic resync_line();
        int unsigned tries;
        tries = 0;
        while (st_phase != DEC_LINE_START && tries < 64) begin
            case (st_phase)
                DEC_CODE:      send_byte(8'hFF);
                DEC_OLD_PIXEL: send_byte((st_byte_idx < 3) ? REPEAT_MARK : 8'hFF);
                default:       send_byte(8'($urandom));
            endcase
            tries++;
        end
    endtask

    task automatic apply_random_config();
        logic [PIX_W-1:0] w;
        logic [PIX_W-1:0] mn;
        logic [PIX_W-1:0] mx;
        case ($urandom_range(0, 5))
            0: begin
                // narrow planar lines
                w  = PIX_W'($urandom_range(1, 16));
                mn = PIX_W'($urandom_range(1, w));
                mx = PIX_W'($urandom_range(w, MAX_LINE_WIDTH));
            end
            1: begin
                // widest line, planar window at or just below it
                w  = PIX_W'(MAX_LINE_WIDTH);
                mn = RST_NEW_MIN_WIDTH;
                mx = ($urandom_range(0, 1) == 0) ? PIX_W'(MAX_LINE_WIDTH)
                                                 : PIX_W'(MAX_LINE_WIDTH - 1);
            end
            2: begin
                // empty planar window
                mn = PIX_W'($urandom_range(2, MAX_LINE_WIDTH));
                mx = PIX_W'($urandom_range(1, mn - 1));
                w  = PIX_W'($urandom_range(1, 12));
            end
            3: begin
                // zero width acts as one
                w  = '0;
                mn = 15'd1;
                mx = PIX_W'($urandom_range(1, MAX_LINE_WIDTH));
            end
            4: begin
                w  = PIX_W'($urandom);
                mn = PIX_W'($urandom);
                mx = PIX_W'($urandom);
            end
            default: begin
                // short lines below the planar window
                w  = PIX_W'($urandom_range(1, 40));
                mn = w + 1;
                mx = PIX_W'(MAX_LINE_WIDTH);
            end
        endcase
        apply_config(w, mn, mx);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset registers: one pixel lines in old style, repeat of the reset pixel
    task automatic test_old_style_repeats();
        send_repeat(8'h00);
        send_repeat(8'h09);
    endtask

    // one pixel planar line: zero code, run and literal past the end, 0 and 255
    task automatic test_planar_codes();
        apply_config(15'd0, 15'd1, 15'd1);
        send_byte(HDR_MARK);
        send_byte(HDR_MARK);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'h81);
        send_byte(8'hFF);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_byte(8'h01);
        send_byte(8'h80);
    endtask

    // header with a wrong second byte, then with the top bit of the third set
    task automatic test_header_fallback();
        send_byte(HDR_MARK);
        send_byte(8'h03);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(HDR_MARK);
        send_byte(HDR_MARK);
        send_byte(8'h80);
        send_byte(8'h55);
    endtask

    // widest line: repeats walk to the last pixel index
    task automatic test_wide_line();
        apply_config(PIX_W'(MAX_LINE_WIDTH), RST_NEW_MIN_WIDTH, PIX_W'(MAX_LINE_WIDTH));
        send_byte(8'h10);
        send_byte(8'h20);
        send_byte(8'h30);
        send_byte(8'h40);
        send_repeat(8'hFD);
        send_repeat(8'h7F);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
    endtask

    // phases of random settings, each carrying a mix of line shapes
    task automatic test_random_streams();
        int unsigned start_items;
        int unsigned phase_start;
        int unsigned phase_len;
        int unsigned sel;
        start_items = bytes_sent;
        while (bytes_sent - start_items < RANDOM_ITEMS) begin
            apply_random_config();
            phase_start = bytes_sent;
            phase_len   = $urandom_range(20, 60);
            while (bytes_sent - phase_start < phase_len) begin
                sel = $urandom_range(0, 99);
                if (sel < 10) begin
                    repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
                end else begin
                    resync_line();
                    if (sel < 22) gen_fallback_line();
                    else if (sel < 80 && planar_allowed() && eff_width() <= PLANAR_GEN_MAX)
                        gen_planar_line(eff_width());
                    else gen_old_line();
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    // compare each popped transaction, then pick the next pop value
    always @(posedge i_clk) begin : rx_check
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (fill_cmd_q.size() == 0) begin
                $error("fill command with none expected: first_pixel %0d count %0d",
                       o_first_pixel, o_pixel_count);
                fail_cnt++;
            end else begin
                want = fill_cmd_q.pop_front();
                check_field("channel_mask", want.channel_mask, o_channel_mask);
                check_field("first_pixel", want.first_pixel, o_first_pixel);
                check_field("pixel_count", want.pixel_count, o_pixel_count);
                check_field("red", want.red, o_red);
                check_field("green", want.green, o_green);
                check_field("blue", want.blue, o_blue);
                check_field("exponent", want.exponent, o_exponent);
                check_field("line_end", want.line_end, o_line_end);
                check_field("overrun", want.overrun, o_overrun);
                cmds_checked++;
                if (want.line_end) lines_ended++;
                if (want.overrun) overruns++;
            end
        end
        // stall pattern changes at random intervals
        rx_tick++;
        if (rx_tick >= rx_next) begin
            rx_mode = $urandom_range(0, 3);
            rx_next = rx_tick + $urandom_range(30, 200);
        end
        if (rx_flush) pop <= 1'b1;
        else begin
            case (rx_mode)
                0: pop <= 1'b1;
                1: pop <= 1'($urandom_range(0, 1));
                2: pop <= ($urandom_range(0, 3) == 0);
                default: pop <= ((rx_tick % 24) < 3);
            endcase
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d commands outstanding",
                     cycle_cnt, fill_cmd_q.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        reset_predictor();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_old_style_repeats();
        test_planar_codes();
        test_header_fallback();
        test_wide_line();
        test_random_streams();

        // receiver always ready at the end so stray commands show up
        rx_flush <= 1'b1;
        drain_results();
        if (!empty) begin
            $error("fill command left over after the stream ended");
            fail_cnt++;
        end

        $display("streamed %0d bytes over %0d register settings", bytes_sent, cfg_settings);
        $display("checked %0d fill commands, %0d line ends, %0d clamped runs",
                 cmds_checked, lines_ended, overruns);
        if (fail_cnt == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
